@@ rtl/mcfsm_pkg.sv @@
// Shared constants, codes and decode functions of the multicycle control unit.
`default_nettype none

package mcfsm_pkg;

    // Field positions inside the instruction word.
    localparam int unsigned InstrWidth  = 32;
    localparam int unsigned OpcodeLsb   = 26;
    localparam int unsigned FieldWidth  = 6;
    localparam int unsigned StateWidth  = 4;

    // Control state codes that the next-state equations and the control signals name.
    localparam logic [StateWidth-1:0] STATE_FETCH     = 4'd0;
    localparam logic [StateWidth-1:0] STATE_DECODE    = 4'd1;
    localparam logic [StateWidth-1:0] STATE_MEM_ADDR  = 4'd2;
    localparam logic [StateWidth-1:0] STATE_MEM_READ  = 4'd3;
    localparam logic [StateWidth-1:0] STATE_WB_LOAD   = 4'd4;
    localparam logic [StateWidth-1:0] STATE_EXEC_R    = 4'd6;
    localparam logic [StateWidth-1:0] STATE_WB_R      = 4'd7;
    localparam logic [StateWidth-1:0] STATE_EXEC_I    = 4'd10;
    localparam logic [StateWidth-1:0] STATE_WB_I      = 4'd11;
    localparam logic [StateWidth-1:0] STATE_WB_ADDI   = 4'd13;
    localparam logic [StateWidth-1:0] STATE_JAL_LINK  = 4'd14;

    // Opcodes.
    localparam logic [FieldWidth-1:0] OP_RTYPE = 6'd0;
    localparam logic [FieldWidth-1:0] OP_J     = 6'd2;
    localparam logic [FieldWidth-1:0] OP_JAL   = 6'd3;
    localparam logic [FieldWidth-1:0] OP_BEQ   = 6'd4;
    localparam logic [FieldWidth-1:0] OP_BNE   = 6'd5;
    localparam logic [FieldWidth-1:0] OP_ADDI  = 6'd8;
    localparam logic [FieldWidth-1:0] OP_ANDI  = 6'd12;
    localparam logic [FieldWidth-1:0] OP_JR    = 6'd20;
    localparam logic [FieldWidth-1:0] OP_JALR  = 6'd21;
    localparam logic [FieldWidth-1:0] OP_LW    = 6'd35;
    localparam logic [FieldWidth-1:0] OP_SW    = 6'd43;

    // Funct codes and the ALU codes they map to.
    localparam logic [FieldWidth-1:0] FUNCT_ADD = 6'd32;
    localparam logic [FieldWidth-1:0] FUNCT_SUB = 6'd34;
    localparam logic [FieldWidth-1:0] FUNCT_AND = 6'd36;
    localparam logic [FieldWidth-1:0] FUNCT_OR  = 6'd37;
    localparam logic [FieldWidth-1:0] FUNCT_SLT = 6'd42;

    localparam logic [FieldWidth-1:0] ALU_ADD = 6'd0;
    localparam logic [FieldWidth-1:0] ALU_SUB = 6'd1;
    localparam logic [FieldWidth-1:0] ALU_AND = 6'd3;
    localparam logic [FieldWidth-1:0] ALU_OR  = 6'd4;
    localparam logic [FieldWidth-1:0] ALU_SLT = 6'd5;

    // Map a funct field to the ALU code; unknown codes pass through.
    function automatic logic [FieldWidth-1:0] map_funct(input logic [FieldWidth-1:0] funct);
        logic [FieldWidth-1:0] code;
        begin
            unique case (funct)
                FUNCT_ADD: code = ALU_ADD;
                FUNCT_SUB: code = ALU_SUB;
                FUNCT_AND: code = ALU_AND;
                FUNCT_OR:  code = ALU_OR;
                FUNCT_SLT: code = ALU_SLT;
                default:   code = funct;
            endcase
            return code;
        end
    endfunction

    // True for every opcode that the control unit knows.
    function automatic logic is_supported(input logic [FieldWidth-1:0] op);
        logic ok;
        begin
            unique case (op) inside
                OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ANDI,
                OP_JR, OP_JALR, OP_LW, OP_SW: ok = 1'b1;
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/multicycle_cpu_control_fsm_unit.sv @@
// Top level of the multicycle processor control unit.
`default_nettype none

// Each accepted item is one control cycle of a multicycle datapath and carries the
// instruction register word. The unit holds a 4-bit control state (fetch after reset)
// and returns one result item per input item: the Moore control signals of the present
// state, the present and following state codes, an opcode-supported flag and the funct
// field mapped to an ALU code. The state advances once per item, as the item moves
// from the input register into the result register. An item passes two register
// stages, the input register and then the result register, and its result is valid
// once the result register has taken it. Throughput is one item per clock while the
// result is not stalled, set by the single state register loop (decode plus next-state
// logic feeding it). Both channels use valid/ready; while a result waits, the input
// register still takes one more item, and only then is the input stalled.
module multicycle_cpu_control_fsm_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] instruction,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       memory_controls,
    output logic [4:0]       register_controls,
    output logic [4:0]       alu_controls,
    output logic [4:0]       pc_controls,
    output logic [3:0]       present_state,
    output logic [3:0]       following_state,
    output logic             opcode_supported,
    output logic [5:0]       alu_function
);

    localparam int unsigned SW = mcfsm_pkg::StateWidth;
    localparam int unsigned FW = mcfsm_pkg::FieldWidth;

    // Pipeline registers.
    logic                                  in_valid_reg;
    logic [mcfsm_pkg::InstrWidth-1:0]      instr_reg;
    logic                                  out_valid_reg;
    logic [SW-1:0]                         control_state_reg;
    logic [SW-1:0]                         control_state_next;

    logic [3:0]    mem_ctl_reg,  mem_ctl_next;
    logic [4:0]    reg_ctl_reg,  reg_ctl_next;
    logic [4:0]    alu_ctl_reg,  alu_ctl_next;
    logic [4:0]    pc_ctl_reg,   pc_ctl_next;
    logic [SW-1:0] present_reg;
    logic [SW-1:0] following_reg;
    logic          supported_reg, supported_next;
    logic [FW-1:0] alu_func_reg,  alu_func_next;

    logic          out_load;
    logic          in_load;
    logic [FW-1:0] op;
    logic [FW-1:0] funct;
    logic          s0, s1, s2, s3;
    logic          in0, in1, in2, in3, in6, in10, in14;
    logic          irwrite;

    // Handshake: the result register takes a new result when empty or being drained.
    assign out_load = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || out_load;
    assign in_load  = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            instr_reg <= instruction;
        end
    end

    // Field extraction and state bits.
    assign op    = instr_reg[mcfsm_pkg::OpcodeLsb +: FW];
    assign funct = instr_reg[FW-1:0];
    assign s0 = control_state_reg[0];
    assign s1 = control_state_reg[1];
    assign s2 = control_state_reg[2];
    assign s3 = control_state_reg[3];

    assign in0  = (control_state_reg == mcfsm_pkg::STATE_FETCH);
    assign in1  = (control_state_reg == mcfsm_pkg::STATE_DECODE);
    assign in2  = (control_state_reg == mcfsm_pkg::STATE_MEM_ADDR);
    assign in3  = (control_state_reg == mcfsm_pkg::STATE_MEM_READ);
    assign in6  = (control_state_reg == mcfsm_pkg::STATE_EXEC_R);
    assign in10 = (control_state_reg == mcfsm_pkg::STATE_EXEC_I);
    assign in14 = (control_state_reg == mcfsm_pkg::STATE_JAL_LINK);
    assign irwrite = in0;

    // Moore control signals of the present state.
    always_comb
    begin
        mem_ctl_next = {s0, (in0 || in3), (!s3 && s2 && !s1 && s0), irwrite};
        reg_ctl_next = {
            (control_state_reg == mcfsm_pkg::STATE_WB_LOAD) ||
            (control_state_reg == mcfsm_pkg::STATE_WB_R)    ||
            (control_state_reg == mcfsm_pkg::STATE_WB_I)    ||
            (control_state_reg == mcfsm_pkg::STATE_WB_ADDI),
            !s1, !s3, (s3 && s2), (!s3 && !s1)};
        alu_ctl_next = {(s1 || s3), (s0 || (!s2 && s1)), (!s3 && !s1),
                        ((!s3 && s2) || (s3 && s1)), s3};
        pc_ctl_next  = {
            (s3 && s2 && !s1) || irwrite || (s3 && s2 && s0) || (s3 && !s1 && s0),
            (s3 && !s1 && !s0), s0, (s1 || (s3 && !s0)), s2};
    end

    // Next-state equations: decode terms from the decode state, memory terms from
    // the address state.
    always_comb
    begin
        logic dec_rtype, dec_j, dec_jal, dec_beq, dec_bne, dec_addi, dec_andi;
        logic dec_jr, dec_jalr, dec_lw, dec_sw;
        logic mem_lw, mem_sw, mem_addi;
        dec_rtype = in1 && (op == mcfsm_pkg::OP_RTYPE);
        dec_j     = in1 && (op == mcfsm_pkg::OP_J);
        dec_jal   = in1 && (op == mcfsm_pkg::OP_JAL);
        dec_beq   = in1 && (op == mcfsm_pkg::OP_BEQ);
        dec_bne   = in1 && (op == mcfsm_pkg::OP_BNE);
        dec_addi  = in1 && (op == mcfsm_pkg::OP_ADDI);
        dec_andi  = in1 && (op == mcfsm_pkg::OP_ANDI);
        dec_jr    = in1 && (op == mcfsm_pkg::OP_JR);
        dec_jalr  = in1 && (op == mcfsm_pkg::OP_JALR);
        dec_lw    = in1 && (op == mcfsm_pkg::OP_LW);
        dec_sw    = in1 && (op == mcfsm_pkg::OP_SW);
        mem_lw    = in2 && (op == mcfsm_pkg::OP_LW);
        mem_sw    = in2 && (op == mcfsm_pkg::OP_SW);
        mem_addi  = in2 && (op == mcfsm_pkg::OP_ADDI);

        control_state_next[0] = in0 || in6 || in10 || in14 || dec_j || dec_jal || dec_jr ||
                                mem_lw || mem_sw || mem_addi;
        control_state_next[1] = dec_lw || dec_sw || dec_addi || mem_lw || dec_jr ||
                                mem_addi || dec_rtype || in6 || dec_andi || in10 ||
                                dec_jalr || in14;
        control_state_next[2] = in3 || mem_sw || dec_rtype || in6 || dec_bne || dec_jal ||
                                dec_jalr || dec_jr || in14;
        control_state_next[3] = dec_beq || dec_j || dec_andi || in10 || dec_bne ||
                                dec_jal || dec_jalr || dec_jr || in14 || mem_addi;
    end

    // Opcode check and funct mapping.
    assign supported_next = mcfsm_pkg::is_supported(op);
    assign alu_func_next  = mcfsm_pkg::map_funct(funct);

    // State register and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_state_reg <= mcfsm_pkg::STATE_FETCH;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                control_state_reg <= control_state_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            mem_ctl_reg   <= mem_ctl_next;
            reg_ctl_reg   <= reg_ctl_next;
            alu_ctl_reg   <= alu_ctl_next;
            pc_ctl_reg    <= pc_ctl_next;
            present_reg   <= control_state_reg;
            following_reg <= control_state_next;
            supported_reg <= supported_next;
            alu_func_reg  <= alu_func_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign memory_controls   = mem_ctl_reg;
    assign register_controls = reg_ctl_reg;
    assign alu_controls      = alu_ctl_reg;
    assign pc_controls       = pc_ctl_reg;
    assign present_state     = present_reg;
    assign following_state   = following_reg;
    assign opcode_supported  = supported_reg;
    assign alu_function      = alu_func_reg;

    // The state register always holds the following state of the last result.
    a_state_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (control_state_reg == following_state))
        else $error("control state does not match the last following state");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

    // IRWrite is asserted in the fetch state only.
    a_irwrite_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (memory_controls[0] == (present_state == mcfsm_pkg::STATE_FETCH)))
        else $error("IRWrite does not match the fetch state");

    // Fetch always moves on to decode.
    a_fetch_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (present_state == mcfsm_pkg::STATE_FETCH)) |->
        (following_state == mcfsm_pkg::STATE_DECODE))
        else $error("fetch state did not advance to decode");

endmodule

`default_nettype wire
